// ----- design/tfd_pkg.sv -----
// Package for the telemetry frame deframer: widths, frame layout and
// sync/command byte values, word array and event types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int NWORDS     = 7;
  localparam int POS_W      = 5;
  localparam int SLOT_W     = 3;
  localparam int CMD_POS_W  = 3;

  // Frame layout
  localparam logic [POS_W-1:0] POS_HUNT      = 5'd0;
  localparam logic [POS_W-1:0] POS_HDR1      = 5'd1;
  localparam logic [POS_W-1:0] POS_FIRST     = 5'd2;
  localparam logic [POS_W-1:0] POS_HEAD_END  = 5'd7;
  localparam logic [POS_W-1:0] POS_ANGLE_LO  = 5'd14;
  localparam logic [POS_W-1:0] POS_ANGLE_END = 5'd21;
  localparam logic [POS_W-1:0] FRAME_LAST    = 5'd22;
  localparam logic [SLOT_W-1:0] SLOT_ANGLE0  = 3'd3;

  // Sync and marker bytes
  localparam logic [BYTE_W-1:0] HDR0     = 8'hFB;
  localparam logic [BYTE_W-1:0] HDR1     = 8'hFF;
  localparam logic [BYTE_W-1:0] CAM_DONE = 8'hBF;

  // Capture command sequence FA 03 00 03 AF
  localparam logic [CMD_POS_W-1:0] CMD_LAST = 3'd4;
  localparam logic [BYTE_W-1:0]    CMD_B0   = 8'hFA;
  localparam logic [BYTE_W-1:0]    CMD_B1   = 8'h03;
  localparam logic [BYTE_W-1:0]    CMD_B2   = 8'h00;
  localparam logic [BYTE_W-1:0]    CMD_B3   = 8'h03;
  localparam logic [BYTE_W-1:0]    CMD_B4   = 8'hAF;

  // Word slots in the published array
  localparam int WORD_SPEED = 0;
  localparam int WORD_TEMP  = 1;
  localparam int WORD_DIST  = 2;
  localparam int WORD_ALF   = 3;
  localparam int WORD_ALB   = 4;
  localparam int WORD_ARF   = 5;
  localparam int WORD_ARB   = 6;

  typedef logic [NWORDS-1:0][WORD_W-1:0] words_t;

  typedef struct packed {
    logic done;
    logic good;
    logic cam_clear;
  } telem_evt_t;

  // Expected byte at a given step of the capture command
  function automatic logic [BYTE_W-1:0] cmd_byte(input logic [CMD_POS_W-1:0] p);
    logic [BYTE_W-1:0] b;
    case (p)
      3'd0:    b = CMD_B0;
      3'd1:    b = CMD_B1;
      3'd2:    b = CMD_B2;
      3'd3:    b = CMD_B3;
      default: b = CMD_B4;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- design/tfd_if.sv -----
// Valid/ready channel interfaces for the deframer: byte input and result.
// Depends on tfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tfd_in_if import tfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              link_select;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, link_select, data_byte, input ready);
  modport sink   (input valid, link_select, data_byte, output ready);
endinterface

interface tfd_out_if import tfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic              frame_good;
  logic [WORD_W-1:0] speed_raw;
  logic [WORD_W-1:0] temperature_raw;
  logic [WORD_W-1:0] distance;
  logic [WORD_W-1:0] angle_left_front;
  logic [WORD_W-1:0] angle_left_back;
  logic [WORD_W-1:0] angle_right_front;
  logic [WORD_W-1:0] angle_right_back;
  logic              camera_busy;

  modport source (output valid, frame_done, frame_good, speed_raw, temperature_raw,
                  distance, angle_left_front, angle_left_back, angle_right_front,
                  angle_right_back, camera_busy, input ready);
  modport sink   (input valid, frame_done, frame_good, speed_raw, temperature_raw,
                  distance, angle_left_front, angle_left_back, angle_right_front,
                  angle_right_back, camera_busy, output ready);
endinterface

`default_nettype wire

// ----- design/tfd_telem.sv -----
// Telemetry link parser: header sync, frame position count, checksum,
// staged and published word registers. Depends on tfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfd_telem import tfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [BYTE_W-1:0] data_byte,
  output      telem_evt_t        evt,
  output      words_t            pub_words
);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  words_t            staged_r, staged_nxt;
  words_t            pub_r, pub_nxt;
  logic              slot_ok;
  logic [POS_W-1:0]  slot_off;
  logic [SLOT_W-1:0] slot;

  // Out-of-range position counts as hunting
  assign pos_eff = (pos_r > FRAME_LAST) ? POS_HUNT : pos_r;

  // Map a frame byte position to its word slot
  always_comb begin
    slot_ok  = 1'b0;
    slot_off = '0;
    slot     = '0;
    if (pos_eff >= POS_FIRST && pos_eff <= POS_HEAD_END) begin
      slot_ok  = 1'b1;
      slot_off = (pos_eff - POS_FIRST) >> 1;
      slot     = slot_off[SLOT_W-1:0];
    end else if (pos_eff >= POS_ANGLE_LO && pos_eff <= POS_ANGLE_END) begin
      slot_ok  = 1'b1;
      slot_off = (pos_eff - POS_ANGLE_LO) >> 1;
      slot     = SLOT_ANGLE0 + slot_off[SLOT_W-1:0];
    end
  end

  // Advance the frame state on one telemetry beat
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    staged_nxt = staged_r;
    pub_nxt    = pub_r;
    evt        = '0;
    if (en) begin
      if (pos_eff == POS_HUNT) begin
        pos_nxt = (data_byte == HDR0) ? POS_HDR1 : POS_HUNT;
      end else if (pos_eff == POS_HDR1) begin
        if (data_byte == HDR1) begin
          sum_nxt = data_byte;
          pos_nxt = POS_FIRST;
        end else begin
          pos_nxt = (data_byte == HDR0) ? POS_HDR1 : POS_HUNT;
        end
      end else if (pos_eff < FRAME_LAST) begin
        sum_nxt = sum_r + data_byte;
        evt.cam_clear = (pos_eff == POS_FIRST) && (data_byte == CAM_DONE);
        if (slot_ok) begin
          if (!pos_eff[0]) begin
            staged_nxt[slot][BYTE_W-1:0] = data_byte;
          end else begin
            staged_nxt[slot][WORD_W-1:BYTE_W] = data_byte;
          end
        end
        pos_nxt = pos_eff + 5'd1;
      end else begin
        // Checksum byte: publish on match, then hunt again
        evt.done = 1'b1;
        if (sum_r == data_byte) begin
          evt.good = 1'b1;
          pub_nxt  = staged_r;
        end
        pos_nxt = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HUNT;
      sum_r    <= '0;
      staged_r <= '0;
      pub_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      staged_r <= staged_nxt;
      pub_r    <= pub_nxt;
    end
  end

  assign pub_words = pub_r;

endmodule

`default_nettype wire

// ----- design/tfd_cmd.sv -----
// Command link matcher for the capture sequence FA 03 00 03 AF.
// Depends on tfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfd_cmd import tfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [BYTE_W-1:0] data_byte,
  output      logic              cam_set
);

  logic [CMD_POS_W-1:0] pos_r, pos_nxt, pos_eff;

  assign pos_eff = (pos_r > CMD_LAST) ? '0 : pos_r;

  // Advance on a match, restart on a break (at step one after FA)
  always_comb begin
    pos_nxt = pos_r;
    cam_set = 1'b0;
    if (en) begin
      if (data_byte == cmd_byte(pos_eff)) begin
        if (pos_eff == CMD_LAST) begin
          cam_set = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_eff + 3'd1;
        end
      end else begin
        pos_nxt = (data_byte == CMD_B0) ? 3'd1 : 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/telemetry_frame_deframer.sv -----
// Telemetry frame deframer top: input beat register, link parsers, result register.
// Throughput: one beat per cycle; the input register and result register form a
// two-stage pipe that stalls only when the result register is full and not taken.
// Reset (rst_n, synchronous, active low) clears positions, sums, words and the flag.
// Depends on tfd_pkg, tfd_if, tfd_telem, tfd_cmd.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_deframer import tfd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tfd_in_if.sink      in_bus,
  tfd_out_if.source   out_bus
);

  logic              s1_valid_r;
  logic              s1_link_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  logic              out_done_r;
  logic              out_good_r;
  logic              cam_r;
  logic              adv;
  logic              fire;
  logic              cam_set;
  telem_evt_t        evt;
  words_t            pub_words;

  // Pipe moves when the result register is free or being taken
  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !s1_valid_r || adv;
  assign fire         = adv && s1_valid_r;

  // Hold the accepted input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_link_r <= in_bus.link_select;
      s1_byte_r <= in_bus.data_byte;
    end
  end

  tfd_telem u_telem (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (fire && s1_link_r),
    .data_byte (s1_byte_r),
    .evt       (evt),
    .pub_words (pub_words)
  );

  tfd_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (fire && !s1_link_r),
    .data_byte (s1_byte_r),
    .cam_set   (cam_set)
  );

  // Camera busy flag: set by the command, cleared by the frame marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r <= 1'b0;
    end else if (cam_set) begin
      cam_r <= 1'b1;
    end else if (evt.cam_clear) begin
      cam_r <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_good_r  <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      out_done_r  <= evt.done;
      out_good_r  <= evt.good;
    end
  end

  // Published words and flag only change when the result register reloads
  assign out_bus.valid             = out_valid_r;
  assign out_bus.frame_done        = out_done_r;
  assign out_bus.frame_good        = out_good_r;
  assign out_bus.speed_raw         = pub_words[WORD_SPEED];
  assign out_bus.temperature_raw   = pub_words[WORD_TEMP];
  assign out_bus.distance          = pub_words[WORD_DIST];
  assign out_bus.angle_left_front  = pub_words[WORD_ALF];
  assign out_bus.angle_left_back   = pub_words[WORD_ALB];
  assign out_bus.angle_right_front = pub_words[WORD_ARF];
  assign out_bus.angle_right_back  = pub_words[WORD_ARB];
  assign out_bus.camera_busy       = cam_r;

  // A good frame is always an ended frame
  a_good_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_good_r |-> out_done_r)
    else $error("frame_good without frame_done");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_bus.ready)
    else $error("input stalled with empty result register");

  // A frame end reaches the result register in the next cycle
  a_done_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && evt.done) |=> (out_valid_r && out_done_r))
    else $error("frame end lost");

  // Flag moves only when a beat is processed
  a_flag_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cam_r))
    else $error("camera flag changed without a beat");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for telemetry_frame_deframer: drives bytes on both links,
// tracks its own copy of the deframer state and checks every result beat.
// Depends on tfd_pkg, tfd_if and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import tfd_pkg::*;

  localparam int FRAME_LEN      = FRAME_LAST + 1;
  localparam int RANDOM_ITEMS   = 820;
  localparam int STEADY_FRAMES  = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum {BODY_RANDOM, BODY_ZERO, BODY_ONES} frame_body_t;

  typedef struct packed {
    logic   done;
    logic   good;
    words_t words;
    logic   busy;
  } deframe_result_t;

  logic clk;
  logic rst_n;

  tfd_in_if  in_bus ();
  tfd_out_if out_bus ();

  telemetry_frame_deframer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Deframer state as the testbench tracks it
  logic [POS_W-1:0]     frame_pos;
  logic [BYTE_W-1:0]    frame_sum;
  words_t               staged_words;
  words_t               shown_words;
  logic [CMD_POS_W-1:0] capture_step;
  logic                 camera_flag;
  logic [BYTE_W-1:0]    capture_cmd [5];

  deframe_result_t expected_results [$];
  int  error_count;
  int  bytes_sent;
  int  stall_left;
  int  stuck_cycles;
  bit  idle_on;

  initial begin
    capture_cmd[0] = CMD_B0;
    capture_cmd[1] = CMD_B1;
    capture_cmd[2] = CMD_B2;
    capture_cmd[3] = CMD_B3;
    capture_cmd[4] = CMD_B4;
  end

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result beat caused by one accepted byte
  task automatic deframe_byte(input logic link, input logic [BYTE_W-1:0] b);
    deframe_result_t r;
    logic [POS_W-1:0] pos;
    int slot;
    r = '0;
    slot = -1;
    if (link) begin
      pos = (frame_pos > FRAME_LAST) ? POS_HUNT : frame_pos;
      if (pos == POS_HUNT) begin
        frame_pos = (b == HDR0) ? POS_HDR1 : POS_HUNT;
      end else if (pos == POS_HDR1) begin
        if (b == HDR1) begin
          frame_sum = b;
          frame_pos = POS_FIRST;
        end else begin
          frame_pos = (b == HDR0) ? POS_HDR1 : POS_HUNT;
        end
      end else if (pos < FRAME_LAST) begin
        frame_sum = frame_sum + b;
        if (pos == POS_FIRST && b == CAM_DONE) camera_flag = 1'b0;
        if (pos >= POS_FIRST && pos <= POS_HEAD_END) slot = (pos - POS_FIRST) / 2;
        else if (pos >= POS_ANGLE_LO && pos <= POS_ANGLE_END)
          slot = SLOT_ANGLE0 + (pos - POS_ANGLE_LO) / 2;
        if (slot >= 0) begin
          if (pos[0] == 1'b0) staged_words[slot][7:0] = b;
          else staged_words[slot][15:8] = b;
        end
        frame_pos = pos + 1'b1;
      end else begin
        // Last byte: compare checksum, publish on match
        r.done = 1'b1;
        if (frame_sum == b) begin
          shown_words = staged_words;
          r.good = 1'b1;
        end
        frame_pos = POS_HUNT;
      end
    end else begin
      if (capture_step > CMD_LAST) capture_step = '0;
      if (b == capture_cmd[capture_step]) begin
        if (capture_step == CMD_LAST) begin
          camera_flag = 1'b1;
          capture_step = '0;
        end else begin
          capture_step = capture_step + 1'b1;
        end
      end else begin
        capture_step = (b == CMD_B0) ? 3'd1 : 3'd0;
      end
    end
    r.words = shown_words;
    r.busy = camera_flag;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                             input logic [WORD_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Predict on input beats, then check output beats against the oldest expectation
  always @(posedge clk) begin
    deframe_result_t exp_r;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) deframe_byte(in_bus.link_select, in_bus.data_byte);
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("frame_done", exp_r.done, out_bus.frame_done);
          check_field("frame_good", exp_r.good, out_bus.frame_good);
          check_field("speed_raw", exp_r.words[WORD_SPEED], out_bus.speed_raw);
          check_field("temperature_raw", exp_r.words[WORD_TEMP], out_bus.temperature_raw);
          check_field("distance", exp_r.words[WORD_DIST], out_bus.distance);
          check_field("angle_left_front", exp_r.words[WORD_ALF], out_bus.angle_left_front);
          check_field("angle_left_back", exp_r.words[WORD_ALB], out_bus.angle_left_back);
          check_field("angle_right_front", exp_r.words[WORD_ARF], out_bus.angle_right_front);
          check_field("angle_right_back", exp_r.words[WORD_ARB], out_bus.angle_right_back);
          check_field("camera_busy", exp_r.busy, out_bus.camera_busy);
        end
      end
    end
  end

  // Result-side stalls in bursts, started at random while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Send one byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic link, input logic [BYTE_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.link_select <= link;
    in_bus.data_byte   <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Byte biased toward the sync, marker and command values
  function automatic logic [BYTE_W-1:0] pick_marker_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 9))
      0:       b = HDR0;
      1:       b = HDR1;
      2:       b = CAM_DONE;
      3:       b = CMD_B0;
      4:       b = CMD_B1;
      5:       b = CMD_B2;
      6:       b = CMD_B4;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Send a whole telemetry frame; optionally sprinkle command-link bytes inside
  task automatic send_frame(input frame_body_t body, input bit sum_ok, input bit clear_cam,
                            input bit mix_cmd);
    logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
    logic [BYTE_W-1:0] sum;
    frame_bytes[0] = HDR0;
    frame_bytes[1] = HDR1;
    for (int i = 2; i < FRAME_LAST; i++) begin
      case (body)
        BODY_ZERO: frame_bytes[i] = 8'h00;
        BODY_ONES: frame_bytes[i] = 8'hFF;
        default:   frame_bytes[i] = 8'($urandom_range(0, 255));
      endcase
    end
    if (clear_cam) frame_bytes[POS_FIRST] = CAM_DONE;
    sum = '0;
    for (int i = 1; i < FRAME_LAST; i++) sum = sum + frame_bytes[i];
    frame_bytes[FRAME_LAST] = sum_ok ? sum : sum ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (mix_cmd && $urandom_range(0, 9) == 0) send_byte(1'b0, pick_marker_byte());
      send_byte(1'b1, frame_bytes[i]);
    end
  endtask

  // Send the capture command, optionally with one byte broken
  task automatic send_capture_cmd(input bit broken);
    int bad_at;
    bad_at = broken ? $urandom_range(0, 4) : -1;
    for (int i = 0; i < 5; i++) begin
      if (i == bad_at) send_byte(1'b0, pick_marker_byte());
      else send_byte(1'b0, capture_cmd[i]);
    end
  endtask

  // Capture command: restart on FA mid-sequence, then complete, then a stray byte
  task automatic test_capture_command();
    send_byte(1'b0, CMD_B0);
    send_byte(1'b0, CMD_B1);
    send_byte(1'b0, CMD_B0);
    send_capture_cmd(1'b0);
    send_byte(1'b0, CMD_B1);
  endtask

  // Header resync: FB then junk returns to hunting, repeated FB holds, then a
  // good frame that clears the camera flag with command bytes mixed in
  task automatic test_header_resync();
    send_byte(1'b1, HDR0);
    send_byte(1'b1, 8'h12);
    send_byte(1'b1, HDR0);
    send_frame(BODY_RANDOM, 1'b1, 1'b1, 1'b1);
  endtask

  // Word extremes: all-ones frame published, all-zero frame with bad checksum dropped
  task automatic test_word_extremes();
    send_frame(BODY_ONES, 1'b1, 1'b0, 1'b0);
    send_frame(BODY_ZERO, 1'b0, 1'b0, 1'b0);
  endtask

  // Mixed random traffic: mostly well-formed frames, some commands and noise
  task automatic test_random_traffic();
    int pick;
    while (bytes_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        send_frame(frame_body_t'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0),
                   $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 2) == 0);
      end else if (pick < 16) begin
        send_capture_cmd($urandom_range(0, 2) == 0);
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(1'($urandom_range(0, 1)), pick_marker_byte());
      end
    end
  endtask

  // Let the block drain completely between a capture command and a frame
  task automatic test_pause_for_results();
    send_capture_cmd(1'b0);
    wait_for_results();
    send_frame(BODY_RANDOM, 1'b1, 1'b1, 1'b0);
  endtask

  // Back-to-back capture commands and frames with no idling on either side
  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (STEADY_FRAMES) begin
      send_capture_cmd(1'b0);
      send_frame(BODY_RANDOM, $urandom_range(0, 3) != 0, $urandom_range(0, 1) == 0, 1'b0);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.link_select = 1'b0;
    in_bus.data_byte   = '0;
    out_bus.ready      = 1'b0;
    frame_pos          = POS_HUNT;
    frame_sum          = '0;
    staged_words       = '0;
    shown_words        = '0;
    capture_step       = '0;
    camera_flag        = 1'b0;
    error_count        = 0;
    bytes_sent         = 0;
    stall_left         = 0;
    stuck_cycles       = 0;
    idle_on            = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_capture_command();
    test_header_resync();
    test_word_extremes();
    test_random_traffic();
    idle_on = 1'b1;
    test_pause_for_results();
    test_steady_stream();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
